>>> src/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master transaction sequencer package
// Shared operation codes, controller command word and buffer depth default.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  // Default depth of the transmit and receive buffers
  localparam int BUFFER_DEPTH_DEF = 64;

  // Host operation codes
  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_START = 2'd1,
    OP_LOAD  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming word and launch buffer reads
    logic exec;     // apply the latched word to state and result registers
  } ctrl_t;

endpackage

`default_nettype wire

>>> src/i2cms_ram.sv
// ----------------------------------------------------------------------------
// I2C sequencer buffer RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = i2cms_pkg::BUFFER_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/i2cms_ctrl.sv
// ----------------------------------------------------------------------------
// I2C sequencer controller
// Two-state machine: take a word, then execute it and strobe the result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  output logic                 done_o,
  output i2cms_pkg::ctrl_t     ctrl_o
);

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          // result registers load at this edge; strobe them next cycle
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o         = (state_q == ST_EXEC);
  assign done_o         = done_q;
  assign ctrl_o.capture = (state_q == ST_IDLE) && start_i;
  assign ctrl_o.exec    = (state_q == ST_EXEC);

endmodule

`default_nettype wire

>>> src/i2cms_dpath.sv
// ----------------------------------------------------------------------------
// I2C sequencer datapath
// Word capture, buffer RAMs, positions, sticky flags and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_dpath #(
  parameter int BUFFER_DEPTH = i2cms_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire i2cms_pkg::ctrl_t ctrl_i,
  input  wire logic [1:0]       operation_i,
  input  wire logic             nack_event_i,
  input  wire logic             rx_event_i,
  input  wire logic             tx_event_i,
  input  wire logic             stop_event_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic [6:0]       tx_count_i,
  input  wire logic [6:0]       rx_count_i,
  input  wire logic             restart_mode_i,
  input  wire logic [5:0]       buf_index_i,
  output logic                  tx_write_valid_o,
  output logic      [7:0]       tx_byte_o,
  output logic                  send_start_o,
  output logic                  send_stop_o,
  output logic                  stop_after_start_o,
  output logic                  transmit_dir_o,
  output logic                  nack_seen_o,
  output logic                  stop_seen_o,
  output logic      [6:0]       rx_received_o,
  output logic                  rx_complete_o,
  output logic      [7:0]       read_data_o
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // latched word
  i2cms_pkg::op_e op_q;
  logic           nack_ev_q, rx_ev_q, tx_ev_q, stop_ev_q, mode_q;
  logic [7:0]     data_q;
  logic [6:0]     tx_cnt_q, rx_cnt_q;
  logic [5:0]     idx_q;

  // transaction state
  logic [CW-1:0] tx_total_q, tx_total_d, tx_pos_q, tx_pos_d;
  logic [CW-1:0] rx_total_q, rx_total_d, rx_pos_q, rx_pos_d;
  logic          restart_q, restart_d, nack_q, nack_d, stop_q, stop_d, dir_q, dir_d;

  // result values of the current word
  logic          wr_valid, start_req, stop_req, stop_as;
  logic [7:0]    wr_byte, rd_byte;
  logic          idx_ok;

  // result registers
  logic          wr_valid_q, start_q, stop_req_q, stop_as_q, complete_q;
  logic [7:0]    wr_byte_q, rd_byte_q;
  logic [CW-1:0] rx_out_q;

  // buffer ports
  logic          tx_we, rx_we;
  logic [7:0]    tx_rdata, rx_rdata;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      op_q      <= i2cms_pkg::op_e'(operation_i);
      nack_ev_q <= nack_event_i;
      rx_ev_q   <= rx_event_i;
      tx_ev_q   <= tx_event_i;
      stop_ev_q <= stop_event_i;
      data_q    <= data_byte_i;
      tx_cnt_q  <= tx_count_i;
      rx_cnt_q  <= rx_count_i;
      mode_q    <= restart_mode_i;
      idx_q     <= buf_index_i;
    end
  end

  assign idx_ok = (32'(idx_q) < BUFFER_DEPTH);

  always_comb begin
    tx_total_d = tx_total_q;
    tx_pos_d   = tx_pos_q;
    rx_total_d = rx_total_q;
    rx_pos_d   = rx_pos_q;
    restart_d  = restart_q;
    nack_d     = nack_q;
    stop_d     = stop_q;
    dir_d      = dir_q;
    wr_valid   = 1'b0;
    wr_byte    = 8'd0;
    start_req  = 1'b0;
    stop_req   = 1'b0;
    stop_as    = 1'b0;
    rd_byte    = 8'd0;
    tx_we      = 1'b0;
    rx_we      = 1'b0;
    case (op_q)
      i2cms_pkg::OP_START: begin
        nack_d     = 1'b0;
        stop_d     = 1'b0;
        tx_total_d = (32'(tx_cnt_q) > BUFFER_DEPTH) ? DEPTH_C : CW'(tx_cnt_q);
        rx_total_d = (32'(rx_cnt_q) > BUFFER_DEPTH) ? DEPTH_C : CW'(rx_cnt_q);
        tx_pos_d   = '0;
        rx_pos_d   = '0;
        restart_d  = mode_q;
        dir_d      = (tx_total_d != '0) || (rx_total_d == '0);
        start_req  = 1'b1;
        stop_as    = !dir_d && (rx_total_d == ONE_C);
      end
      i2cms_pkg::OP_LOAD: begin
        tx_we = idx_ok;
      end
      i2cms_pkg::OP_READ: begin
        rd_byte = idx_ok ? rx_rdata : 8'd0;
      end
      default: begin
        if (nack_ev_q) begin
          nack_d   = 1'b1;
          stop_req = 1'b1;
        end
        if (rx_ev_q) begin
          // drop the byte once the buffer is full
          if (rx_pos_q < DEPTH_C) begin
            rx_we    = 1'b1;
            rx_pos_d = rx_pos_q + ONE_C;
          end
          if ((rx_total_q > ONE_C) && (rx_pos_d == rx_total_q - ONE_C)) begin
            stop_req = 1'b1;
          end
        end
        if (tx_ev_q) begin
          if (tx_pos_q < tx_total_q) begin
            wr_valid = 1'b1;
            wr_byte  = tx_rdata;
            tx_pos_d = tx_pos_q + ONE_C;
          end else if (!restart_q) begin
            stop_req = 1'b1;
          end else begin
            // turn around into receive with a repeated start
            dir_d     = 1'b0;
            start_req = 1'b1;
            stop_as   = (rx_total_q == ONE_C);
          end
        end
        if (stop_ev_q) begin
          stop_d = 1'b1;
        end
      end
    endcase
    if (!ctrl_i.exec) begin
      tx_we = 1'b0;
      rx_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_total_q <= '0;
      tx_pos_q   <= '0;
      rx_total_q <= '0;
      rx_pos_q   <= '0;
      restart_q  <= 1'b0;
      nack_q     <= 1'b0;
      stop_q     <= 1'b0;
      dir_q      <= 1'b0;
    end else if (ctrl_i.exec) begin
      tx_total_q <= tx_total_d;
      tx_pos_q   <= tx_pos_d;
      rx_total_q <= rx_total_d;
      rx_pos_q   <= rx_pos_d;
      restart_q  <= restart_d;
      nack_q     <= nack_d;
      stop_q     <= stop_d;
      dir_q      <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      wr_valid_q <= wr_valid;
      wr_byte_q  <= wr_byte;
      start_q    <= start_req;
      stop_req_q <= stop_req;
      stop_as_q  <= stop_as;
      rd_byte_q  <= rd_byte;
      rx_out_q   <= rx_pos_d;
      complete_q <= (rx_pos_d >= rx_total_d);
    end
  end

  // transmit buffer: read at the current position, written by host loads
  i2cms_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (AW'(idx_q)),
    .wdata_i (data_q),
    .raddr_i (AW'(tx_pos_q)),
    .rdata_o (tx_rdata)
  );

  // receive buffer: written by received bytes, read by host
  i2cms_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (AW'(rx_pos_q)),
    .wdata_i (data_q),
    .raddr_i (AW'(buf_index_i)),
    .rdata_o (rx_rdata)
  );

  assign tx_write_valid_o   = wr_valid_q;
  assign tx_byte_o          = wr_byte_q;
  assign send_start_o       = start_q;
  assign send_stop_o        = stop_req_q;
  assign stop_after_start_o = stop_as_q;
  assign transmit_dir_o     = dir_q;
  assign nack_seen_o        = nack_q;
  assign stop_seen_o        = stop_q;
  assign rx_received_o      = 7'(rx_out_q);
  assign rx_complete_o      = complete_q;
  assign read_data_o        = rd_byte_q;

endmodule

`default_nettype wire

>>> src/i2c_master_transaction_sequencer_unit.sv
// ----------------------------------------------------------------------------
// I2C master transaction sequencer
// Drives a byte-level I2C engine through a write-then-read transaction.
// ----------------------------------------------------------------------------
// A word accepted at a clock edge (start_i high, busy_o low) is captured,
// executed in ST_EXEC, and its result shown with done_o for exactly one cycle.
// No word is accepted while busy_o is high; one may be in the done_o cycle.
// ST_EXEC exists because the buffer RAMs have a registered read port.
// Reset (rst_ni low, asynchronous): positions, totals, flags, direction and
// the controller clear at once; buffer contents stay undefined until written.
// The receiver cannot stall; done_o is a single-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transaction_sequencer_unit #(
  parameter int BUFFER_DEPTH = i2cms_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // command side
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [1:0] operation_i,
  input  wire logic       nack_event_i,
  input  wire logic       rx_event_i,
  input  wire logic       tx_event_i,
  input  wire logic       stop_event_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [6:0] tx_count_i,
  input  wire logic [6:0] rx_count_i,
  input  wire logic       restart_mode_i,
  input  wire logic [5:0] buf_index_i,
  // result side
  output logic            done_o,
  output logic            tx_write_valid_o,
  output logic [7:0]      tx_byte_o,
  output logic            send_start_o,
  output logic            send_stop_o,
  output logic            stop_after_start_o,
  output logic            transmit_dir_o,
  output logic            nack_seen_o,
  output logic            stop_seen_o,
  output logic [6:0]      rx_received_o,
  output logic            rx_complete_o,
  output logic [7:0]      read_data_o
);

  // Controller commands: capture on acceptance, execute in the cycle after.
  i2cms_pkg::ctrl_t ctrl;

  // Controller: take a word when idle, hold busy while it executes, and
  // raise done_o in the cycle after execution when results are registered.
  i2cms_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .ctrl_o (ctrl)
  );

  // Datapath: latch the word and launch both buffer reads on capture
  // (transmit buffer at the current transmit position, receive buffer at
  // the host index). On execute, handle events in the order NACK, received
  // byte, transmit ready, stop; advance positions, saturating at the depth;
  // drop a received byte once the buffer is full; load the result registers.
  i2cms_dpath #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .operation_i       (operation_i),
    .nack_event_i      (nack_event_i),
    .rx_event_i        (rx_event_i),
    .tx_event_i        (tx_event_i),
    .stop_event_i      (stop_event_i),
    .data_byte_i       (data_byte_i),
    .tx_count_i        (tx_count_i),
    .rx_count_i        (rx_count_i),
    .restart_mode_i    (restart_mode_i),
    .buf_index_i       (buf_index_i),
    .tx_write_valid_o  (tx_write_valid_o),
    .tx_byte_o         (tx_byte_o),
    .send_start_o      (send_start_o),
    .send_stop_o       (send_stop_o),
    .stop_after_start_o(stop_after_start_o),
    .transmit_dir_o    (transmit_dir_o),
    .nack_seen_o       (nack_seen_o),
    .stop_seen_o       (stop_seen_o),
    .rx_received_o     (rx_received_o),
    .rx_complete_o     (rx_complete_o),
    .read_data_o       (read_data_o)
  );

endmodule

`default_nettype wire

>>> src/i2cms_chk.sv
// ----------------------------------------------------------------------------
// I2C sequencer port checker
// Timing and consistency properties seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic done_o,
  input wire logic tx_write_valid_o,
  input wire logic transmit_dir_o
);

  // an accepted word always yields its result strobe after it executes
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("result strobe missing two cycles after acceptance");

  // the result cycle is free to accept the next word
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("busy while presenting a result");

  // busy only follows an acceptance
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy raised without a start");

  // bytes are only fed to the engine while in transmit direction
  a_tx_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && tx_write_valid_o |-> transmit_dir_o)
    else $error("transmit byte issued in receive direction");

endmodule

bind i2c_master_transaction_sequencer_unit i2cms_chk u_i2cms_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .tx_write_valid_o(tx_write_valid_o),
  .transmit_dir_o  (transmit_dir_o)
);

`default_nettype wire
